// ----- rtl/ohle_pkg.sv -----
// Package for the ordered handle list engine: sizes, operation and status
// codes, and the cell control types. No dependencies.
package ohle_pkg;

   localparam int CAPACITY = 64;
   localparam int HANDLE_W = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PIN_W    = 8;
   localparam int FUNC_W   = 4;
   localparam int STAT_W   = 2;

   typedef logic [HANDLE_W-1:0] handle_type;

   localparam logic [FUNC_W-1:0] FN_APPEND  = 4'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_RM_KEY  = 4'd2;
   localparam logic [FUNC_W-1:0] FN_RM_POS  = 4'd3;
   localparam logic [FUNC_W-1:0] FN_FWD     = 4'd4;
   localparam logic [FUNC_W-1:0] FN_BACK    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_TO_END  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_TO_HEAD = 4'd7;
   localparam logic [FUNC_W-1:0] FN_FIND    = 4'd8;
   localparam logic [FUNC_W-1:0] FN_CLEAR   = 4'd9;
   localparam logic [FUNC_W-1:0] FN_TRUNC   = 4'd10;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_UP,
      CELL_FROM_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        live;
      logic        sel;
   } cell_ctrl_type;

endpackage

// ----- rtl/ohle_cell.sv -----
// One list cell: holds one entry, compares it with the key, shifts with
// its neighbors. Depends on ohle_pkg.
module ohle_cell import ohle_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  handle_type    key,
   input  handle_type    up_entry,
   input  handle_type    down_entry,
   output handle_type    entry,
   output logic          match,
   output handle_type    pick
);

   handle_type entry_ff, entry_in;
   logic       match_ff, match_in;

   always_comb begin
      unique case (ctrl.op)
         CELL_LOAD:      entry_in = key;
         CELL_FROM_UP:   entry_in = up_entry;
         CELL_FROM_DOWN: entry_in = down_entry;
         default:        entry_in = entry_ff;
      endcase
      match_in = ctrl.live && (entry_ff == key);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;
   // drive the entry only when this cell is the one addressed by position
   assign pick  = ctrl.sel ? entry_ff : '0;

endmodule

// ----- rtl/ohle_locate.sv -----
// First-match locator: turns the cells' match flags into the lowest
// matching index. Depends on ohle_pkg.
module ohle_locate import ohle_pkg::*; (
   input  logic [CAPACITY-1:0] match,
   output logic                found,
   output logic [IDX_W-1:0]    first
);

   logic [CAPACITY-1:0] below;
   logic [CAPACITY-1:0] lead;

   always_comb begin
      below[0] = 1'b0;
      for (int i = 1; i < CAPACITY; i++) begin
         below[i] = below[i-1] | match[i-1];
      end
      lead  = match & ~below;
      found = |match;
      first = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lead[i]) begin
            first = first | IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/ordered_handle_list_engine_top.sv -----
// Ordered handle list engine: a chain of list cells with a two-step sequencer.
// A request goes through compare, then apply, which registers the strobe and
// may accept the next request. Busy is high for the compare cycle only, in
// which every live cell checks its entry against the handle. The apply cycle
// shifts the chain and registers the result. The receiver cannot stall.
// Reset clears the count, the sequencer and the strobe; entries are not reset.
module ordered_handle_list_engine_top import ohle_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic [PIN_W-1:0]    req_position,
   output logic                rsp_valid,
   output logic [CNT_W-1:0]    rsp_result_position,
   output logic [HANDLE_W-1:0] rsp_result_handle,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [STAT_W-1:0]   rsp_status
);

   // Sequencer: idle, compare (cells register match flags), apply.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // Request held for the compare and apply cycles.
   logic [FUNC_W-1:0] func_ff;
   handle_type        handle_ff;
   logic [PIN_W-1:0]  pos_ff;

   logic [CNT_W-1:0] count_ff, count_in;

   // Result registers.
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  rpos_ff, rpos_in;
   handle_type        rh_ff, rh_in;
   logic [STAT_W-1:0] stat_ff, stat_in;

   // Cell chain.
   cell_ctrl_type       ctrl [CAPACITY];
   handle_type          cell_entry [CAPACITY];
   handle_type          cell_pick [CAPACITY];
   logic [CAPACITY-1:0] cell_match;

   // Entry addressed by position, captured in the compare cycle.
   handle_type pick_any, pick_ff;

   logic             found;
   logic [IDX_W-1:0] first;
   logic [CNT_W-1:0] f_c;

   // Shift plan for the apply cycle.
   logic             load_en, dn_en, up_en;
   logic [CNT_W-1:0] load_idx, dn_lo, dn_hi, up_lo, up_hi, ins_k;
   logic             full, needs_handle;

   assign accept = start && !busy;
   assign busy   = (state_ff == S_CMP);

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = start ? S_CMP : S_IDLE;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: state_in = start ? S_CMP : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == S_APPLY);
      end
   end

   // Payload registers: latch the request, capture the picked entry, and
   // load the result at the end of the apply cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         handle_ff <= req_handle;
         pos_ff    <= req_position;
      end
      pick_ff <= pick_any;
      if (state_ff == S_APPLY) begin
         rpos_ff <= rpos_in;
         rh_ff   <= rh_in;
         stat_ff <= stat_in;
      end
   end

   ohle_locate u_locate (
      .match (cell_match),
      .found (found),
      .first (first)
   );

   assign f_c = CNT_W'(first);

   // Plan the operation from the match flags registered in the compare cycle.
   always_comb begin
      load_en  = 1'b0;
      load_idx = '0;
      dn_en    = 1'b0;
      dn_lo    = '0;
      dn_hi    = '0;
      up_en    = 1'b0;
      up_lo    = '0;
      up_hi    = '0;
      count_in = count_ff;
      rpos_in  = '0;
      rh_in    = '0;
      stat_in  = STAT_OK;
      full     = (count_ff == CNT_W'(CAPACITY));
      needs_handle = (func_ff <= FN_FIND) && (func_ff != FN_RM_POS);

      // Clamp the insert position to 1..count+1, kept here as a 0-based index.
      if (pos_ff == '0) begin
         ins_k = '0;
      end else if (pos_ff > PIN_W'(count_ff)) begin
         ins_k = count_ff;
      end else begin
         ins_k = CNT_W'(pos_ff - PIN_W'(1));
      end

      priority if (func_ff > FN_TRUNC) begin
         stat_in = STAT_MISS;
      end else if (needs_handle && (handle_ff == '0)) begin
         stat_in = STAT_ZERO;
      end else begin
         unique case (func_ff)
            FN_APPEND: begin
               if (full) begin
                  stat_in = STAT_FULL;
               end else begin
                  load_en  = 1'b1;
                  load_idx = count_ff;
                  count_in = count_ff + CNT_W'(1);
                  rpos_in  = count_ff + CNT_W'(1);
               end
            end
            FN_INSERT: begin
               if (full) begin
                  stat_in = STAT_FULL;
               end else begin
                  load_en  = 1'b1;
                  load_idx = ins_k;
                  dn_en    = 1'b1;
                  dn_lo    = ins_k + CNT_W'(1);
                  dn_hi    = count_ff;
                  count_in = count_ff + CNT_W'(1);
                  rpos_in  = ins_k + CNT_W'(1);
               end
            end
            FN_RM_KEY: begin
               if (!found) begin
                  stat_in = STAT_MISS;
               end else begin
                  up_en    = 1'b1;
                  up_lo    = f_c;
                  up_hi    = CNT_W'(CAPACITY);
                  count_in = count_ff - CNT_W'(1);
                  rpos_in  = f_c + CNT_W'(1);
               end
            end
            FN_RM_POS: begin
               if ((pos_ff == '0) || (pos_ff > PIN_W'(count_ff))) begin
                  stat_in = STAT_MISS;
               end else begin
                  up_en    = 1'b1;
                  up_lo    = CNT_W'(pos_ff - PIN_W'(1));
                  up_hi    = CNT_W'(CAPACITY);
                  count_in = count_ff - CNT_W'(1);
                  rpos_in  = CNT_W'(pos_ff);
                  rh_in    = pick_ff;
               end
            end
            FN_FWD: begin
               if (!found) begin
                  stat_in = STAT_MISS;
               end else if ((f_c + CNT_W'(1)) < count_ff) begin
                  up_en    = 1'b1;
                  up_lo    = f_c;
                  up_hi    = f_c + CNT_W'(1);
                  load_en  = 1'b1;
                  load_idx = f_c + CNT_W'(1);
                  rpos_in  = f_c + CNT_W'(2);
               end else begin
                  rpos_in  = f_c + CNT_W'(1);
               end
            end
            FN_BACK: begin
               if (!found) begin
                  stat_in = STAT_MISS;
               end else if (f_c != '0) begin
                  dn_en    = 1'b1;
                  dn_lo    = f_c;
                  dn_hi    = f_c;
                  load_en  = 1'b1;
                  load_idx = f_c - CNT_W'(1);
                  rpos_in  = f_c;
               end else begin
                  rpos_in  = f_c + CNT_W'(1);
               end
            end
            FN_TO_END: begin
               if (found) begin
                  up_en    = 1'b1;
                  up_lo    = f_c;
                  up_hi    = CNT_W'(CAPACITY);
                  load_en  = 1'b1;
                  load_idx = count_ff - CNT_W'(1);
                  rpos_in  = count_ff;
               end else if (full) begin
                  stat_in = STAT_FULL;
               end else begin
                  load_en  = 1'b1;
                  load_idx = count_ff;
                  count_in = count_ff + CNT_W'(1);
                  rpos_in  = count_ff + CNT_W'(1);
               end
            end
            FN_TO_HEAD: begin
               if (!found && full) begin
                  stat_in = STAT_FULL;
               end else begin
                  load_en  = 1'b1;
                  load_idx = '0;
                  dn_en    = 1'b1;
                  dn_lo    = CNT_W'(1);
                  dn_hi    = found ? f_c : count_ff;
                  count_in = found ? count_ff : count_ff + CNT_W'(1);
                  rpos_in  = CNT_W'(1);
               end
            end
            FN_FIND: begin
               if (!found) begin
                  stat_in = STAT_MISS;
               end else begin
                  rpos_in = f_c + CNT_W'(1);
               end
            end
            FN_CLEAR: begin
               count_in = '0;
            end
            FN_TRUNC: begin
               if (pos_ff < PIN_W'(count_ff)) begin
                  count_in = CNT_W'(pos_ff);
               end
            end
            default: begin
               stat_in = STAT_MISS;
            end
         endcase
      end

      // Only the apply cycle may touch the list.
      if (state_ff != S_APPLY) begin
         count_in = count_ff;
      end
   end

   // Per-cell control: load beats a shift; shifts only in the apply cycle.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         ctrl[i].live = (CNT_W'(i) < count_ff);
         ctrl[i].sel  = (PIN_W'(i + 1) == pos_ff);
         ctrl[i].op   = CELL_HOLD;
         if (state_ff == S_APPLY) begin
            priority if (load_en && (CNT_W'(i) == load_idx)) begin
               ctrl[i].op = CELL_LOAD;
            end else if (dn_en && (CNT_W'(i) >= dn_lo) && (CNT_W'(i) <= dn_hi)) begin
               ctrl[i].op = CELL_FROM_DOWN;
            end else if (up_en && (CNT_W'(i) >= up_lo) && (CNT_W'(i) < up_hi)) begin
               ctrl[i].op = CELL_FROM_UP;
            end
         end
      end
   end

   // Gather the entry addressed by position; at most one cell drives it.
   always_comb begin
      pick_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_any = pick_any | cell_pick[i];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      handle_type up_nb, dn_nb;
      if (g == CAPACITY - 1) begin : g_top_edge
         assign up_nb = '0;
      end else begin : g_top_inner
         assign up_nb = cell_entry[g+1];
      end
      if (g == 0) begin : g_bot_edge
         assign dn_nb = '0;
      end else begin : g_bot_inner
         assign dn_nb = cell_entry[g-1];
      end
      ohle_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .key        (handle_ff),
         .up_entry   (up_nb),
         .down_entry (dn_nb),
         .entry      (cell_entry[g]),
         .match      (cell_match[g]),
         .pick       (cell_pick[g])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_position = rpos_ff;
   assign rsp_result_handle   = rh_ff;
   assign rsp_entry_count     = count_ff;
   assign rsp_status          = stat_ff;

   // The result strobe of an accepted request follows its compare and apply states.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_valid)
      else $error("result strobe missing after accepted request");

   // A strobe only follows an apply cycle.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_APPLY))
      else $error("result strobe without apply cycle");

   // The list never grows past capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A full status is only reported by a full list.
   a_full_stat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("full status with room left");

   // Rejected or missed requests leave the count untouched.
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_APPLY) && (stat_in != STAT_OK)) |=> $stable(count_ff))
      else $error("count changed by a failed request");

endmodule

// ----- verif/ohle_checker.sv -----
`timescale 1ns / 100ps
// Response checker for the ordered handle list engine: predicts each request's answer.
// Depends on ohle_pkg for sizes, operation codes and status codes.
module ohle_checker import ohle_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic [PIN_W-1:0]    req_position,
   input  logic                rsp_valid,
   input  logic [CNT_W-1:0]    rsp_result_position,
   input  logic [HANDLE_W-1:0] rsp_result_handle,
   input  logic [CNT_W-1:0]    rsp_entry_count,
   input  logic [STAT_W-1:0]   rsp_status,
   output int                  mismatch_count,
   output int                  pending_count,
   output int                  checked_count,
   output int                  full_count
);

   typedef struct packed {
      logic [CNT_W-1:0]  position;
      handle_type        handle;
      logic [CNT_W-1:0]  count;
      logic [STAT_W-1:0] status;
   } list_answer_type;

   handle_type      slots [CAPACITY];
   int              slot_count = 0;
   list_answer_type pending_answers [$];
   int              bad_results = 0;
   int              answers_seen = 0;
   int              full_answers = 0;

   // index of the first match, or slot_count when absent
   function automatic int locate_handle(input handle_type h);
      for (int i = 0; i < slot_count; i++) begin
         if (slots[i] == h) return i;
      end
      return slot_count;
   endfunction

   function automatic void close_gap(input int idx);
      for (int i = idx; i + 1 < slot_count; i++) slots[i] = slots[i + 1];
      slot_count--;
   endfunction

   function automatic void open_gap(input int idx, input handle_type h);
      for (int i = slot_count; i > idx; i--) slots[i] = slots[i - 1];
      slots[idx] = h;
      slot_count++;
   endfunction

   function automatic list_answer_type predict_list_op(input logic [FUNC_W-1:0] fn,
                                                       input handle_type h,
                                                       input logic [PIN_W-1:0] pin);
      list_answer_type a;
      int idx;
      int p;
      a = '0;
      a.status = STAT_OK;
      p = 0;
      if (fn > FN_TRUNC) begin
         a.status = STAT_MISS;
      end else if (fn <= FN_FIND && fn != FN_RM_POS && h == '0) begin
         a.status = STAT_ZERO;
      end else begin
         case (fn)
            FN_APPEND: begin
               if (slot_count >= CAPACITY) a.status = STAT_FULL;
               else begin
                  open_gap(slot_count, h);
                  p = slot_count;
               end
            end
            FN_INSERT: begin
               if (slot_count >= CAPACITY) a.status = STAT_FULL;
               else begin
                  // clamp into 1..count+1
                  p = int'(pin);
                  if (p == 0) p = 1;
                  else if (p > slot_count) p = slot_count + 1;
                  open_gap(p - 1, h);
               end
            end
            FN_RM_KEY: begin
               idx = locate_handle(h);
               if (idx >= slot_count) a.status = STAT_MISS;
               else begin
                  close_gap(idx);
                  p = idx + 1;
               end
            end
            FN_RM_POS: begin
               if (pin == '0 || int'(pin) > slot_count) a.status = STAT_MISS;
               else begin
                  p = int'(pin);
                  a.handle = slots[p - 1];
                  close_gap(p - 1);
               end
            end
            FN_FWD, FN_BACK: begin
               idx = locate_handle(h);
               if (idx >= slot_count) a.status = STAT_MISS;
               else begin
                  // an edge entry stays where it is
                  if (fn == FN_FWD && idx + 1 < slot_count) begin
                     slots[idx] = slots[idx + 1];
                     slots[idx + 1] = h;
                     idx++;
                  end else if (fn == FN_BACK && idx > 0) begin
                     slots[idx] = slots[idx - 1];
                     slots[idx - 1] = h;
                     idx--;
                  end
                  p = idx + 1;
               end
            end
            FN_TO_END, FN_TO_HEAD: begin
               idx = locate_handle(h);
               if (idx >= slot_count && slot_count >= CAPACITY) a.status = STAT_FULL;
               else begin
                  if (idx < slot_count) close_gap(idx);
                  if (fn == FN_TO_END) begin
                     open_gap(slot_count, h);
                     p = slot_count;
                  end else begin
                     open_gap(0, h);
                     p = 1;
                  end
               end
            end
            FN_FIND: begin
               idx = locate_handle(h);
               if (idx >= slot_count) a.status = STAT_MISS;
               else p = idx + 1;
            end
            FN_CLEAR: slot_count = 0;
            FN_TRUNC: if (int'(pin) < slot_count) slot_count = int'(pin);
            default: a.status = STAT_MISS;
         endcase
      end
      a.position = CNT_W'(p);
      a.count    = CNT_W'(slot_count);
      return a;
   endfunction

   function automatic void note_failure(input string msg);
      if (bad_results < 10) $display("%0t: mismatch: %s", $realtime, msg);
      bad_results++;
   endfunction

   always @(posedge clock) begin
      list_answer_type want;
      list_answer_type got;
      if (reset) begin
         pending_answers.delete();
         slot_count = 0;
      end else begin
         // retire the oldest answer before queueing a new request
         if (rsp_valid) begin
            got.position = rsp_result_position;
            got.handle   = rsp_result_handle;
            got.count    = rsp_entry_count;
            got.status   = rsp_status;
            answers_seen++;
            if (got.status == STAT_FULL) full_answers++;
            if (pending_answers.size() == 0) begin
               note_failure($sformatf({"response with no request outstanding: ",
                                       "pos %0d handle %h count %0d status %0d"},
                                      got.position, got.handle, got.count, got.status));
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  note_failure($sformatf({"expected pos %0d handle %h count %0d status %0d, ",
                                          "got pos %0d handle %h count %0d status %0d"},
                                         want.position, want.handle, want.count, want.status,
                                         got.position, got.handle, got.count, got.status));
               end
            end
         end
         if (start && !busy) begin
            pending_answers.push_back(predict_list_op(req_func, req_handle, req_position));
         end
      end
      pending_count  <= pending_answers.size();
      mismatch_count <= bad_results;
      checked_count  <= answers_seen;
      full_count     <= full_answers;
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the ordered handle list engine testbench: clock, reset, request stimulus and verdict.
// Depends on ohle_pkg, ordered_handle_list_engine_top and ohle_checker.
module testbench;
   import ohle_pkg::*;

   typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_type;

   localparam int POOL_SIZE      = 24;
   localparam int PHASES         = 10;
   localparam int ITEMS_PER_PHASE = 163;
   localparam int QUIET_PHASE    = 3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [FUNC_W-1:0]   req_func = FN_APPEND;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic [PIN_W-1:0]    req_position = '0;
   logic                busy;
   logic                rsp_valid;
   logic [CNT_W-1:0]    rsp_result_position;
   logic [HANDLE_W-1:0] rsp_result_handle;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic [STAT_W-1:0]   rsp_status;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_count;

   int         requests_sent = 0;
   int         directed_sent = 0;
   logic [6:0] list_fill = '0;    // last entry count seen, used only to aim positions
   handle_type handle_pool [POOL_SIZE];
   mix_type    phase_plan [PHASES] = '{MIX_GROW, MIX_CHURN, MIX_GROW, MIX_GROW, MIX_CHURN,
                                       MIX_SHRINK, MIX_CHURN, MIX_GROW, MIX_CHURN, MIX_SHRINK};

   // 10 ns period: two delays, high then low
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_handle_list_engine_top u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_handle          (req_handle),
      .req_position        (req_position),
      .rsp_valid           (rsp_valid),
      .rsp_result_position (rsp_result_position),
      .rsp_result_handle   (rsp_result_handle),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_status          (rsp_status)
   );

   ohle_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_handle          (req_handle),
      .req_position        (req_position),
      .rsp_valid           (rsp_valid),
      .rsp_result_position (rsp_result_position),
      .rsp_result_handle   (rsp_result_handle),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .checked_count       (checked_count),
      .full_count          (full_count)
   );

   // track the list length from the responses so random positions land near it
   always @(posedge clock) begin
      if (rsp_valid) list_fill <= rsp_entry_count;
   end

   // Present one request and hold it until the engine takes it. Called at a
   // rising edge; start is left high so a back-to-back request keeps it high.
   task automatic issue_request(input logic [FUNC_W-1:0] fn, input handle_type h,
                                input logic [PIN_W-1:0] pin);
      req_func     <= fn;
      req_handle   <= h;
      req_position <= pin;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   // Drop start for a number of cycles.
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait until every queued request has answered.
   task automatic drain_list_engine();
      hold_off(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [FUNC_W-1:0] pick_operation(input mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 45) return FN_APPEND;
            if (r < 70) return FN_INSERT;
            if (r < 76) return FN_TO_END;
            if (r < 80) return FN_TO_HEAD;
            if (r < 86) return FN_FIND;
            if (r < 90) return FN_FWD;
            if (r < 93) return FN_BACK;
            if (r < 96) return FN_RM_KEY;
            if (r < 99) return FN_RM_POS;
         end
         MIX_CHURN: begin
            if (r < 12) return FN_APPEND;
            if (r < 24) return FN_INSERT;
            if (r < 36) return FN_RM_KEY;
            if (r < 48) return FN_RM_POS;
            if (r < 58) return FN_FWD;
            if (r < 68) return FN_BACK;
            if (r < 76) return FN_TO_END;
            if (r < 84) return FN_TO_HEAD;
            if (r < 94) return FN_FIND;
            if (r < 96) return FN_TRUNC;
            if (r < 97) return FN_CLEAR;
         end
         default: begin
            if (r < 5)  return FN_APPEND;
            if (r < 10) return FN_INSERT;
            if (r < 38) return FN_RM_KEY;
            if (r < 66) return FN_RM_POS;
            if (r < 72) return FN_FWD;
            if (r < 78) return FN_BACK;
            if (r < 84) return FN_FIND;
            if (r < 90) return FN_TO_END;
            if (r < 94) return FN_TO_HEAD;
            if (r < 97) return FN_TRUNC;
            if (r < 98) return FN_CLEAR;
         end
      endcase
      // remaining slice: codes the engine does not know
      return FUNC_W'($urandom_range(int'(FN_TRUNC) + 1, 15));
   endfunction

   function automatic handle_type pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 12) return handle_type'($urandom);
      return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [PIN_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return PIN_W'($urandom_range(0, 255));
      if (r < 15) return '0;
      return PIN_W'($urandom_range(1, int'(list_fill) + 2));
   endfunction

   // Fresh set of likely handles per phase: duplicates and hits stay common.
   task automatic refill_pool();
      handle_type v;
      handle_pool[0] = '1;
      handle_pool[1] = handle_type'(1);
      handle_pool[2] = {1'b1, {(HANDLE_W - 1){1'b0}}};
      for (int i = 3; i < POOL_SIZE; i++) begin
         do v = handle_type'($urandom); while (v == '0);
         handle_pool[i] = v;
      end
   endtask

   initial begin
      int guard;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, zero handles, clamps, edges, duplicates, odd codes.
      issue_request(FN_FIND,    32'h0000_0005, 8'd0);    // miss on an empty list
      issue_request(FN_APPEND,  '0,            8'd0);    // zero handle rejected
      issue_request(FN_RM_POS,  '0,            8'd0);    // position 0
      issue_request(FN_RM_POS,  '0,            8'd1);    // past the end of an empty list
      issue_request(FN_APPEND,  32'hFFFF_FFFF, 8'd0);
      issue_request(FN_APPEND,  32'h0000_0001, 8'd0);
      issue_request(FN_INSERT,  32'h8000_0000, 8'd0);    // position 0 becomes 1
      issue_request(FN_INSERT,  32'h5A5A_5A5A, 8'd255);  // clamp to count+1
      issue_request(FN_INSERT,  32'h0000_0001, 8'd2);    // duplicate ahead of the first copy
      issue_request(FN_INSERT,  '0,            8'd3);    // zero handle rejected
      issue_request(FN_FIND,    32'h0000_0001, 8'd0);    // first match wins
      issue_request(FN_FWD,     32'hFFFF_FFFF, 8'd0);
      issue_request(FN_BACK,    32'h8000_0000, 8'd0);    // already at the front
      issue_request(FN_FWD,     32'h5A5A_5A5A, 8'd0);    // already at the back
      issue_request(FN_FWD,     '0,            8'd0);
      issue_request(FN_BACK,    32'h0000_0001, 8'd0);
      issue_request(FN_TO_END,  32'h1234_5678, 8'd0);    // absent handle gets added
      issue_request(FN_TO_HEAD, 32'h5A5A_5A5A, 8'd0);
      issue_request(FN_RM_KEY,  32'h0000_0001, 8'd0);
      issue_request(FN_RM_KEY,  32'h0000_DEAD, 8'd0);    // not present
      issue_request(FN_RM_POS,  '0,            8'd200);  // past the end
      issue_request(FN_RM_POS,  '0,            8'd2);
      issue_request(FN_TRUNC,   '0,            8'd100);  // longer than the list: no change
      issue_request(FN_TRUNC,   '0,            8'd2);
      issue_request(FN_RM_POS,  '0,            8'd255);
      issue_request(4'd11,      32'h0000_0007, 8'd1);    // unknown codes
      issue_request(4'd15,      32'hFFFF_FFFF, 8'd255);
      issue_request(FN_CLEAR,   '0,            8'd0);
      directed_sent = requests_sent;
      drain_list_engine();

      // Random phases. Each ends with a full drain; one phase runs with no gaps.
      for (int ph = 0; ph < PHASES; ph++) begin
         refill_pool();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            logic [FUNC_W-1:0] fn;
            fn = pick_operation(phase_plan[ph]);
            issue_request(fn, pick_handle(),
                          (fn == FN_TRUNC) ? PIN_W'($urandom_range(0, int'(list_fill) + 1))
                                           : pick_position());
            if (ph != QUIET_PHASE && $urandom_range(0, 99) < 16) hold_off($urandom_range(1, 4));
         end
         drain_list_engine();
      end

      // Wait out any straggler, bounded, then give the pipe its latency.
      start <= 1'b0;
      guard = 0;
      while (pending_count != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);

      $display("Sent %0d requests (%0d directed, the rest in grow, churn and shrink phases).",
               requests_sent, directed_sent);
      $display("Checked %0d responses; %0d reported a full list.", checked_count, full_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d bad responses, %0d requests left unanswered", mismatch_count,
                  pending_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timeout: engine stopped answering");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
